// File: hw/rtl/sc1a_pkg.sv
// package for the scan code set 1 to ascii decoder
// holds key codes and the two-column character tables
// no dependencies
package sc1a_pkg;

    localparam int KEY_COUNT = 59;

    typedef logic [6:0] ascii_t;
    typedef logic [6:0] key_code_t;

    localparam logic [7:0] PREFIX_CODE   = 8'hE0;
    localparam key_code_t  KEY_NONE      = 7'h00;
    localparam key_code_t  KEY_BACKSPACE = 7'h0E;
    localparam key_code_t  KEY_LBRACKET  = 7'h1A;
    localparam key_code_t  KEY_RBRACKET  = 7'h1B;
    localparam key_code_t  KEY_CTRL      = 7'h1D;
    localparam key_code_t  KEY_SEMICOLON = 7'h27;
    localparam key_code_t  KEY_QUOTE     = 7'h28;
    localparam key_code_t  KEY_BACKTICK  = 7'h29;
    localparam key_code_t  KEY_LSHIFT    = 7'h2A;
    localparam key_code_t  KEY_BACKSLASH = 7'h2B;
    localparam key_code_t  KEY_COMMA     = 7'h33;
    localparam key_code_t  KEY_PERIOD    = 7'h34;
    localparam key_code_t  KEY_SLASH     = 7'h35;
    localparam key_code_t  KEY_RSHIFT    = 7'h36;
    localparam key_code_t  KEY_ALT       = 7'h38;
    localparam key_code_t  KEY_CAPS      = 7'h3A;

    localparam ascii_t PLAIN_TABLE [KEY_COUNT] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    localparam ascii_t SHIFT_TABLE [KEY_COUNT] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

endpackage

// File: hw/rtl/scancode_set1_to_ascii_unit.sv
// scan code set 1 to ascii decoder, top level
// input register, one pass of decode logic, result register
// depends on sc1a_pkg
//
// usage: one keyboard byte per input transaction on in_valid/in_stall/scan_byte.
// a 0xE0 byte marks the next byte as extended and produces nothing; break codes
// release ctrl, alt or shift and produce nothing; modifier and caps lock makes
// update the held flags and produce nothing. a printable key produces one output
// transaction with ascii_char; an unhandled make produces one with unknown_key set.
// ctrl_held and alt_held carry the flags at the time of that byte.
// a result passes the input register, then the result register, to out_valid.
// throughput: one byte per cycle unless out_stall holds a result; the single decode
// pass between the two registers sets it and also updates the modifier flags.
// reset clears both registers' valid bits, the modifier flags, caps lock and the
// extended prefix flag. while out_stall holds a waiting result, one more byte can
// be taken into the input register; after that in_stall rises until the result
// is taken.
module scancode_set1_to_ascii_unit
    import sc1a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] ascii_char,
    output logic       unknown_key,
    output logic       ctrl_held,
    output logic       alt_held
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    ascii_t     ascii_reg;
    logic       unknown_reg, ctrl_out_reg, alt_out_reg;

    logic ctrl_down_reg, ctrl_down_next;
    logic shift_down_reg, shift_down_next;
    logic alt_down_reg, alt_down_next;
    logic caps_on_reg, caps_on_next;
    logic ext_reg, ext_next;

    logic      advance, accept;
    key_code_t key;
    logic      is_prefix, is_break, handled, shift_only, upper;
    ascii_t    table_char;
    logic      res_valid, res_unknown;
    ascii_t    res_char;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign key       = in_byte_reg[6:0];
    assign is_prefix = (in_byte_reg == PREFIX_CODE);
    assign is_break  = in_byte_reg[7];

    always_comb
    begin
        if (ext_reg)
        begin
            handled = (key == KEY_CTRL) || (key == KEY_ALT);
        end
        else
        begin
            handled = (key != KEY_NONE) && (key <= KEY_CAPS);
        end
    end

    assign shift_only = !ext_reg && ((key < KEY_BACKSPACE) || (key == KEY_BACKTICK)
        || (key == KEY_LBRACKET) || (key == KEY_RBRACKET) || (key == KEY_BACKSLASH)
        || (key == KEY_SEMICOLON) || (key == KEY_QUOTE) || (key == KEY_COMMA)
        || (key == KEY_PERIOD) || (key == KEY_SLASH));
    assign upper      = shift_only ? shift_down_reg : (shift_down_reg ^ caps_on_reg);
    assign table_char = upper ? SHIFT_TABLE[key[5:0]] : PLAIN_TABLE[key[5:0]];

    always_comb
    begin
        ctrl_down_next  = ctrl_down_reg;
        shift_down_next = shift_down_reg;
        alt_down_next   = alt_down_reg;
        caps_on_next    = caps_on_reg;
        ext_next        = ext_reg;
        res_valid       = 1'b0;
        res_unknown     = 1'b0;
        res_char        = '0;
        if (advance)
        begin
            if (is_prefix)
            begin
                ext_next = 1'b1;
            end
            else
            begin
                ext_next = 1'b0;
                if (is_break)
                begin
                    if (key == KEY_CTRL)
                    begin
                        ctrl_down_next = 1'b0;
                    end
                    else if (key == KEY_ALT)
                    begin
                        alt_down_next = 1'b0;
                    end
                    else if (!ext_reg && ((key == KEY_LSHIFT) || (key == KEY_RSHIFT)))
                    begin
                        shift_down_next = 1'b0;
                    end
                end
                else if (!handled)
                begin
                    res_valid   = 1'b1;
                    res_unknown = 1'b1;
                end
                else if (table_char != '0)
                begin
                    res_valid = 1'b1;
                    res_char  = table_char;
                end
                else if (key == KEY_CTRL)
                begin
                    ctrl_down_next = 1'b1;
                end
                else if ((key == KEY_LSHIFT) || (key == KEY_RSHIFT))
                begin
                    shift_down_next = 1'b1;
                end
                else if (key == KEY_ALT)
                begin
                    alt_down_next = 1'b1;
                end
                else if (key == KEY_CAPS)
                begin
                    caps_on_next = !caps_on_reg;
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ctrl_down_reg  <= 1'b0;
            shift_down_reg <= 1'b0;
            alt_down_reg   <= 1'b0;
            caps_on_reg    <= 1'b0;
            ext_reg        <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            ctrl_down_reg  <= ctrl_down_next;
            shift_down_reg <= shift_down_next;
            alt_down_reg   <= alt_down_next;
            caps_on_reg    <= caps_on_next;
            ext_reg        <= ext_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= scan_byte;
        end
        if (advance && res_valid)
        begin
            ascii_reg    <= res_char;
            unknown_reg  <= res_unknown;
            ctrl_out_reg <= ctrl_down_reg;
            alt_out_reg  <= alt_down_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ascii_char  = ascii_reg;
    assign unknown_key = unknown_reg;
    assign ctrl_held   = ctrl_out_reg;
    assign alt_held    = alt_out_reg;

endmodule

// File: verif/tb_scancode_set1_to_ascii_unit.sv
// testbench for scancode_set1_to_ascii_unit: directed and random scan code set 1 bytes
// checks every output transaction against a bit-accurate decoder model held here
// depends on sc1a_pkg and the rtl of the unit
module tb_scancode_set1_to_ascii_unit
    import sc1a_pkg::*;
();

    localparam int ITEM_TOTAL  = 1950;
    localparam int HOLD_CYCLES = 300;

    localparam logic [6:0] PLAIN_CHARS [59] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    localparam logic [6:0] SHIFTED_CHARS [59] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    localparam logic [7:0] OPENING_BYTES [26] = '{
        PREFIX_CODE, PREFIX_CODE, {1'b0, KEY_CTRL}, 8'h1E,
        PREFIX_CODE, {1'b1, KEY_CTRL},
        PREFIX_CODE, {1'b0, KEY_ALT}, PREFIX_CODE, 8'h47, PREFIX_CODE, {1'b1, KEY_ALT},
        8'h00, 8'h3B, 8'h7F, 8'h01,
        {1'b0, KEY_CAPS}, 8'h10, 8'h02, {1'b0, KEY_LSHIFT}, 8'h10, {1'b0, KEY_BACKTICK},
        {1'b1, KEY_LSHIFT}, 8'hFF, {1'b0, KEY_CAPS}, 8'h39
    };

    typedef struct {
        logic [6:0] ch;
        logic       unknown;
        logic       ctrl;
        logic       alt;
    } key_result_t;

    class keyboard_scoreboard;
        key_result_t pending_chars[$];
        bit ctrl_down, shift_down, alt_down, caps_on, prefix_seen;
        int errors = 0;

        function void note_byte(logic [7:0] b);
            key_code_t   key;
            bit          ext;
            bit          upper;
            logic [6:0]  ch;
            if (b == PREFIX_CODE)
            begin
                prefix_seen = 1'b1;
                return;
            end
            ext = prefix_seen;
            prefix_seen = 1'b0;
            key = b[6:0];
            if (b[7])
            begin
                case (key)
                    KEY_CTRL: ctrl_down = 1'b0;
                    KEY_ALT: alt_down = 1'b0;
                    KEY_LSHIFT, KEY_RSHIFT: if (!ext) shift_down = 1'b0;
                    default: ;
                endcase
                return;
            end
            if (ext ? !(key == KEY_CTRL || key == KEY_ALT)
                    : (key == KEY_NONE || key >= KEY_COUNT))
            begin
                pending_chars.push_back('{7'h00, 1'b1, ctrl_down, alt_down});
                return;
            end
            if (key < KEY_BACKSPACE || key inside {KEY_BACKTICK, KEY_LBRACKET, KEY_RBRACKET,
                    KEY_BACKSLASH, KEY_SEMICOLON, KEY_QUOTE, KEY_COMMA, KEY_PERIOD, KEY_SLASH})
                upper = shift_down;
            else
                upper = shift_down ^ caps_on;
            ch = upper ? SHIFTED_CHARS[key[5:0]] : PLAIN_CHARS[key[5:0]];
            if (ch != 7'h00)
            begin
                pending_chars.push_back('{ch, 1'b0, ctrl_down, alt_down});
                return;
            end
            case (key)
                KEY_CTRL: ctrl_down = 1'b1;
                KEY_LSHIFT, KEY_RSHIFT: shift_down = 1'b1;
                KEY_ALT: alt_down = 1'b1;
                KEY_CAPS: caps_on = !caps_on;
                default: ;
            endcase
        endfunction

        function void check_char(logic [6:0] ch, logic unknown, logic ctrl, logic alt);
            key_result_t want;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected output transaction: ascii_char %h unknown_key %b", ch, unknown);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (want.ch !== ch)
            begin
                $error("ascii_char expected %h got %h", want.ch, ch);
                errors++;
            end
            if (want.unknown !== unknown)
            begin
                $error("unknown_key expected %b got %b", want.unknown, unknown);
                errors++;
            end
            if (want.ctrl !== ctrl)
            begin
                $error("ctrl_held expected %b got %b", want.ctrl, ctrl);
                errors++;
            end
            if (want.alt !== alt)
            begin
                $error("alt_held expected %b got %b", want.alt, alt);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] scan_byte;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] ascii_char;
    logic       unknown_key;
    logic       ctrl_held;
    logic       alt_held;

    keyboard_scoreboard sb = new;
    bit calm = 1'b0;
    bit hold_sink = 1'b0;
    int sent_count = 0;

    scancode_set1_to_ascii_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ascii_char  (ascii_char),
        .unknown_key (unknown_key),
        .ctrl_held   (ctrl_held),
        .alt_held    (alt_held)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_byte(scan_byte);
        if (out_valid && !out_stall)
            sb.check_char(ascii_char, unknown_key, ctrl_held, alt_held);
    end

    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        scan_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        if (!calm && !hold_sink && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // receiver side: random stall bursts, one long hold on request
    initial
    begin
        bit stall_now;
        int span;
        bit holding;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            holding = hold_sink;
            if (holding)
            begin
                stall_now = 1'b1;
                span = HOLD_CYCLES;
            end
            else if (calm)
            begin
                stall_now = 1'b0;
                span = 1;
            end
            else
            begin
                stall_now = ($urandom_range(0, 2) == 0);
                span = $urandom_range(1, 14);
            end
            out_stall <= stall_now;
            repeat (span) @(posedge clk);
            if (holding)
                hold_sink = 1'b0;
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        key_code_t chord_keys [4];
        logic [7:0] k;
        key_code_t  mod;
        bit         ext;
        bit         pressure_done;
        chord_keys = '{KEY_CTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_ALT};
        pressure_done = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        scan_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // prefixes, extended modifiers, unknown makes, caps and shift interplay
        foreach (OPENING_BYTES[i])
            send_byte(OPENING_BYTES[i]);

        while (sent_count < ITEM_TOTAL)
        begin
            if (sent_count > ITEM_TOTAL - 300)
                calm = 1'b1;
            if (!pressure_done && sent_count > 800)
            begin
                pressure_done = 1'b1;
                hold_sink = 1'b1;
                repeat (24) send_byte({1'b0, 7'($urandom_range(16, 25))});
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    k = 8'($urandom_range(1, KEY_COUNT - 1));
                    send_byte(k);
                    if ($urandom_range(0, 1) == 1)
                        send_byte(k | 8'h80);
                end
                4, 5:
                begin
                    mod = chord_keys[$urandom_range(0, 3)];
                    ext = (mod == KEY_CTRL || mod == KEY_ALT) && $urandom_range(0, 1) == 1;
                    if (ext)
                        send_byte(PREFIX_CODE);
                    send_byte({1'b0, mod});
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(1, KEY_COUNT - 1)));
                    if (ext)
                        send_byte(PREFIX_CODE);
                    send_byte({1'b1, mod});
                end
                6:
                begin
                    send_byte({1'b0, KEY_CAPS});
                    send_byte({1'b1, KEY_CAPS});
                end
                7:
                begin
                    send_byte(PREFIX_CODE);
                    send_byte(8'($urandom_range(0, 255)));
                end
                default:
                    send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        in_valid <= 1'b0;

        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
